@@ src/bsag_pkg.sv @@
// Shared types and constants for the broadcast strided address generator.
`default_nettype none
package bsag_pkg;

  localparam int OFF_BITS  = 40;
  localparam int CFG_BITS  = 64;
  localparam int BASE_BITS = 32;
  localparam int RANK_BITS = 3;

  typedef enum logic [2:0] {
    REG_RANK         = 3'd0,
    REG_OUT_SHAPE    = 3'd1,
    REG_FIRST_SHAPE  = 3'd2,
    REG_FIRST_STRIDE = 3'd3,
    REG_SECOND_SHAPE = 3'd4,
    REG_SECOND_STRIDE= 3'd5,
    REG_FIRST_BASE   = 3'd6,
    REG_SECOND_BASE  = 3'd7
  } reg_index_t;

  // running offsets and error flag that travel with each word
  typedef struct packed {
    logic                bad;
    logic [OFF_BITS-1:0] off_a;
    logic [OFF_BITS-1:0] off_b;
  } acc_t;

endpackage
`default_nettype wire

@@ src/bsag_dim.sv @@
// One output dimension: pipelined divide by the size, then stride multiply and accumulate.
`default_nettype none
module bsag_dim import bsag_pkg::*; #(
  parameter int INDEX_BITS = 32,
  parameter int DIM_BITS   = 16,
  parameter int STEP       = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [INDEX_BITS-1:0] in_curr,
  input  wire acc_t                  in_acc,
  input  wire logic                  active,
  input  wire logic [DIM_BITS-1:0]   size,
  input  wire logic [DIM_BITS-1:0]   stride_a,
  input  wire logic [DIM_BITS-1:0]   stride_b,
  output logic                       out_valid,
  output logic [INDEX_BITS-1:0]      out_curr,
  output acc_t                       out_acc
);

  localparam int NS = (INDEX_BITS + STEP - 1) / STEP;

  logic                  vld  [0:NS];
  logic [INDEX_BITS-1:0] orig [0:NS];
  logic [INDEX_BITS-1:0] dq   [0:NS];
  logic [DIM_BITS-1:0]   rem  [0:NS];
  acc_t                  acc  [0:NS];

  assign vld[0]  = in_valid;
  assign orig[0] = in_curr;
  assign dq[0]   = in_curr;
  assign rem[0]  = '0;
  assign acc[0]  = in_acc;

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_div
      logic [INDEX_BITS-1:0] dq_n;
      logic [DIM_BITS-1:0]   rem_n;

      // restoring division, STEP quotient bits per stage
      always_comb begin
        logic [DIM_BITS:0] t;
        dq_n  = dq[s];
        rem_n = rem[s];
        t     = '0;
        for (int j = 0; j < STEP; j++) begin
          if (s * STEP + j < INDEX_BITS) begin
            t = {rem_n, dq_n[INDEX_BITS-1]};
            if (t >= {1'b0, size}) begin
              t = t - {1'b0, size};
              dq_n = {dq_n[INDEX_BITS-2:0], 1'b1};
            end else begin
              dq_n = {dq_n[INDEX_BITS-2:0], 1'b0};
            end
            rem_n = t[DIM_BITS-1:0];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s+1] <= 1'b0;
        end else begin
          vld[s+1] <= vld[s];
        end
        orig[s+1] <= orig[s];
        dq[s+1]   <= dq_n;
        rem[s+1]  <= rem_n;
        acc[s+1]  <= acc[s];
      end
    end
  endgenerate

  logic                    mul_valid;
  logic [INDEX_BITS-1:0]   mul_curr;
  logic [2*DIM_BITS-1:0]   prod_a;
  logic [2*DIM_BITS-1:0]   prod_b;
  acc_t                    mul_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= vld[NS];
    end
    mul_curr      <= active ? dq[NS] : orig[NS];
    prod_a        <= active ? rem[NS] * stride_a : '0;
    prod_b        <= active ? rem[NS] * stride_b : '0;
    mul_acc.off_a <= acc[NS].off_a;
    mul_acc.off_b <= acc[NS].off_b;
    // a zero size stops the walk: flag it, offsets are dropped later
    mul_acc.bad   <= acc[NS].bad | (active && size == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mul_valid;
    end
    out_curr      <= mul_curr;
    out_acc.bad   <= mul_acc.bad;
    out_acc.off_a <= mul_acc.off_a + OFF_BITS'(prod_a);
    out_acc.off_b <= mul_acc.off_b + OFF_BITS'(prod_b);
  end

endmodule
`default_nettype wire

@@ src/broadcast_strided_address_generator_top.sv @@
// Top level: configuration registers, per-dimension pipeline chain and result stage.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  command   | element_index                          | start & !busy
//  result    | first_offset, second_offset, out_of_range | done, one cycle, no stall
//  config    | wr_index, wr_data                      | wr_en
//
// One word enters every cycle; busy stays low. The pipeline depth is set
// by the divider stages of each dimension, four quotient bits per stage.
// Synchronous reset clears the valid bits and loads the register defaults.
// Results cannot be held off; each stands on the ports for one cycle.
`default_nettype none
module broadcast_strided_address_generator_top import bsag_pkg::*; #(
  parameter int MAX_RANK   = 4,
  parameter int DIM_BITS   = 16,
  parameter int INDEX_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [INDEX_BITS-1:0] element_index,
  input  wire logic                  wr_en,
  input  wire logic [2:0]            wr_index,
  input  wire logic [CFG_BITS-1:0]   wr_data,
  output logic                       done,
  output logic [OFF_BITS-1:0]        first_offset,
  output logic [OFF_BITS-1:0]        second_offset,
  output logic                       out_of_range
);

  localparam logic [CFG_BITS-1:0] ONES_PACKED = 64'd281479271743489;

  logic [8:0]           rank_fields;
  logic [CFG_BITS-1:0]  out_shape, shape_a, stride_a, shape_b, stride_b;
  logic [BASE_BITS-1:0] base_a, base_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_fields <= 9'd73;
      out_shape   <= ONES_PACKED;
      shape_a     <= ONES_PACKED;
      stride_a    <= '0;
      shape_b     <= ONES_PACKED;
      stride_b    <= '0;
      base_a      <= '0;
      base_b      <= '0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_RANK:          rank_fields <= wr_data[8:0];
        REG_OUT_SHAPE:     out_shape   <= wr_data;
        REG_FIRST_SHAPE:   shape_a     <= wr_data;
        REG_FIRST_STRIDE:  stride_a    <= wr_data;
        REG_SECOND_SHAPE:  shape_b     <= wr_data;
        REG_SECOND_STRIDE: stride_b    <= wr_data;
        REG_FIRST_BASE:    base_a      <= wr_data[BASE_BITS-1:0];
        REG_SECOND_BASE:   base_b      <= wr_data[BASE_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // unpack entries; an entry past bit 63 reads as zero
  logic [DIM_BITS-1:0] e_out [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] e_sha [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] e_sta [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] e_shb [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] e_stb [0:MAX_RANK-1];

  genvar k;
  generate
    for (k = 0; k < MAX_RANK; k++) begin : g_ent
      localparam int LO = k * DIM_BITS;
      if (LO >= CFG_BITS) begin : g_zero
        assign e_out[k] = '0;
        assign e_sha[k] = '0;
        assign e_sta[k] = '0;
        assign e_shb[k] = '0;
        assign e_stb[k] = '0;
      end else begin : g_sel
        assign e_out[k] = DIM_BITS'(out_shape >> LO);
        assign e_sha[k] = DIM_BITS'(shape_a >> LO);
        assign e_sta[k] = DIM_BITS'(stride_a >> LO);
        assign e_shb[k] = DIM_BITS'(shape_b >> LO);
        assign e_stb[k] = DIM_BITS'(stride_b >> LO);
      end
    end
  endgenerate

  int r_out, r_a, r_b;
  always_comb begin
    r_out = int'(rank_fields[2:0]);
    r_a   = int'(rank_fields[5:3]);
    r_b   = int'(rank_fields[8:6]);
    if (r_out > MAX_RANK) r_out = MAX_RANK;
    if (r_a > MAX_RANK)   r_a   = MAX_RANK;
    if (r_b > MAX_RANK)   r_b   = MAX_RANK;
  end

  // slot s handles output dimension out_rank-1-s, innermost first
  logic                slot_act  [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] slot_size [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] eff_a     [0:MAX_RANK-1];
  logic [DIM_BITS-1:0] eff_b     [0:MAX_RANK-1];

  logic                  v   [0:MAX_RANK];
  logic [INDEX_BITS-1:0] cur [0:MAX_RANK];
  acc_t                  acc [0:MAX_RANK];

  genvar s;
  generate
    for (s = 0; s < MAX_RANK; s++) begin : g_slot
      logic [DIM_BITS-1:0] eff_a_next, eff_b_next;

      always_comb begin
        slot_act[s]  = (s < r_out);
        slot_size[s] = '0;
        eff_a_next   = '0;
        eff_b_next   = '0;
        for (int j = 0; j < MAX_RANK; j++) begin
          if (j == r_out - 1 - s) slot_size[s] = e_out[j];
          if (j == r_a - 1 - s && e_sha[j] != DIM_BITS'(1)) eff_a_next = e_sta[j];
          if (j == r_b - 1 - s && e_shb[j] != DIM_BITS'(1)) eff_b_next = e_stb[j];
        end
      end

      // strides are first used many stages in, so hold them in registers
      always_ff @(posedge clk) begin
        eff_a[s] <= eff_a_next;
        eff_b[s] <= eff_b_next;
      end

      bsag_dim #(
        .INDEX_BITS (INDEX_BITS),
        .DIM_BITS   (DIM_BITS),
        .STEP       (4)
      ) u_dim (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (v[s]),
        .in_curr   (cur[s]),
        .in_acc    (acc[s]),
        .active    (slot_act[s]),
        .size      (slot_size[s]),
        .stride_a  (eff_a[s]),
        .stride_b  (eff_b[s]),
        .out_valid (v[s+1]),
        .out_curr  (cur[s+1]),
        .out_acc   (acc[s+1])
      );
    end
  endgenerate

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start;
    end
    cur[0]       <= element_index;
    acc[0].bad   <= 1'b0;
    acc[0].off_a <= OFF_BITS'(base_a);
    acc[0].off_b <= OFF_BITS'(base_b);
  end

  logic bad_final;
  assign bad_final = acc[MAX_RANK].bad || (cur[MAX_RANK] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[MAX_RANK];
    end
    out_of_range  <= bad_final;
    first_offset  <= bad_final ? '0 : acc[MAX_RANK].off_a;
    second_offset <= bad_final ? '0 : acc[MAX_RANK].off_b;
  end

endmodule
`default_nettype wire
